// ----- rtl/rapal_pkg.sv -----
// Shared types and constants for the reverse-and-add palindrome search block.
`default_nettype none

package rapal_pkg;

  // Search bound on the number of reverse-and-add steps
  localparam int ITER_LIMIT = 256;

  // Field widths
  localparam int VAL_W  = 31;
  localparam int STEPS_W = 9;
  localparam int CFG_IDX_W = 2;

  // Step counter must hold ITER_LIMIT + 1 and the 9-bit config values
  localparam int STEP_W = ($clog2(ITER_LIMIT + 2) > STEPS_W) ?
                          $clog2(ITER_LIMIT + 2) : STEPS_W;

  // Decimal layout: a 31-bit value has up to 10 digits, a sum up to 11
  localparam int VAL_DIGITS = 10;
  localparam int SUM_DIGITS = 11;
  localparam int DIG_W      = 4;
  localparam int BCD_W      = 4 * VAL_DIGITS;
  localparam int BITCNT_W   = $clog2(VAL_W);

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;

  typedef logic [VAL_DIGITS-1:0][3:0] val_bcd_t;
  typedef logic [SUM_DIGITS-1:0][3:0] sum_bcd_t;

  // 2147483647 in decimal, least significant digit first
  localparam logic [3:0] INT_MAX_BCD [SUM_DIGITS] = '{
    4'd7, 4'd4, 4'd6, 4'd3, 4'd8, 4'd4, 4'd7, 4'd4, 4'd1, 4'd2, 4'd0
  };

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET    = 2'd0,
    REG_MIN_STEPS = 2'd1,
    REG_MAX_STEPS = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEN,
    ST_ADD,
    ST_EVAL,
    ST_DONE
  } state_e;

  // One double-dabble step: add 3 to each digit of 5 or more, shift in a bit
  function automatic val_bcd_t dabble(input val_bcd_t bcd, input logic bit_in);
    val_bcd_t          corr;
    logic [BCD_W-1:0]  flat;
    corr = bcd;
    for (int i = 0; i < VAL_DIGITS; i++) begin
      if (corr[i] >= 4'd5) begin
        corr[i] = corr[i] + 4'd3;
      end
    end
    flat = {corr[VAL_DIGITS-1:0]};
    return {flat[BCD_W-2:0], bit_in};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/reverse_add_palindrome_search.sv -----
// Top level of the reverse-and-add palindrome search block.
//
// Usage:
//  - Input stream (s_axis_*): one request carries a start value and a tag.
//    A request is taken only while the search engine is free.
//  - Output stream (m_axis_*): one result per request: found, overflowed,
//    the step count at which the search ended and the echoed tag.
//  - Configuration: cfg_we_i writes cfg_data_i to cfg_idx_i (0 target value,
//    1 minimum steps, 2 maximum steps); users write only while idle, unchecked.
// Sequencing: the start value and the target are converted from binary to
//  decimal one bit a cycle, then each reverse-and-add step passes a length
//  state, a digit pass through a single decimal digit adder and an
//  evaluation state; at the end the result is handed to the output register
//  once it is free, and the next request can be taken when the sequencer
//  is back in idle.
// Throughput: one request at a time; the digit adder sets the step time.
// The output register holds a finished result so the next request can be
//  taken while the receiver stalls; a second result waits in the engine
//  until the output register is free.
// Reset: clears the sequencer and the output valid, sets target 0,
//  minimum steps 0 and maximum steps 256.
`default_nettype none

module reverse_add_palindrome_search (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [rapal_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rapal_pkg::VAL_W-1:0]         cfg_data_i,
  // Request stream
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // [30:0] start_value, [61:31] start_tag, [63:62] zero
  input  wire logic [rapal_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Result stream
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [0] found, [1] overflowed, [10:2] step_count, [41:11] echoed_tag,
  // [47:42] zero
  output      logic [rapal_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  import rapal_pkg::*;

  // Configuration registers
  logic [VAL_W-1:0]   target_q;
  logic [STEPS_W-1:0] min_q;
  logic [STEPS_W-1:0] max_q;

  // Sequencer
  state_e state_q, state_d;

  // Datapath
  logic [VAL_W-1:0]    bin_q;      // start value, shifted out MSB first
  logic [VAL_W-1:0]    tbin_q;     // target value, shifted out MSB first
  logic [VAL_W-1:0]    tag_q;
  logic [BITCNT_W-1:0] bit_q;
  val_bcd_t            cur_q;
  val_bcd_t            tgt_q;
  sum_bcd_t            sum_q;
  logic [DIG_W-1:0]    len_q;
  logic [DIG_W-1:0]    dig_q;
  logic                carry_q;
  logic                gt_q;
  logic                eq_q;
  logic [STEP_W-1:0]   step_q;
  logic                found_q;
  logic                ovf_q;

  // Output register
  logic                m_valid_q;
  logic                res_found_q;
  logic                res_ovf_q;
  logic [STEPS_W-1:0]  res_step_q;
  logic [VAL_W-1:0]    res_tag_q;

  // Control
  logic s_accept;
  logic conv_last;
  logic add_last;
  logic out_free;
  logic hit;
  logic stop_nx;
  logic [STEP_W-1:0] step_nx;

  // Sequencer outputs
  logic load_en;
  logic conv_en;
  logic len_en;
  logic add_en;
  logic eval_en;
  logic out_load;

  // Digit adder signals
  logic [DIG_W-1:0] len_c;
  logic             dig_in_val;
  logic             dig_in_rev;
  logic [DIG_W-1:0] rev_idx;
  logic [3:0]       dig_a;
  logic [3:0]       dig_b;
  logic [3:0]       dig_t;
  logic [4:0]       dig_raw;
  logic [3:0]       dig_s;
  logic             dig_c;

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign conv_last = (bit_q == BITCNT_W'(VAL_W - 1));
  assign add_last  = (dig_q == DIG_W'(SUM_DIGITS - 1));
  assign out_free  = !m_valid_q || m_axis_tready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      min_q    <= '0;
      max_q    <= STEPS_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET:    target_q <= cfg_data_i;
        REG_MIN_STEPS: min_q    <= cfg_data_i[STEPS_W-1:0];
        REG_MAX_STEPS: max_q    <= cfg_data_i[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Decision terms for the end of a step
  assign hit     = (step_q >= STEP_W'(min_q)) && eq_q;
  assign step_nx = step_q + STEP_W'(1);
  assign stop_nx = ((step_nx >= STEP_W'(min_q)) && (step_nx > STEP_W'(max_q))) ||
                   (step_nx > STEP_W'(ITER_LIMIT));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_CONV;
      ST_CONV: if (conv_last) state_d = ST_LEN;
      ST_LEN:  state_d = ST_ADD;
      ST_ADD:  if (add_last) state_d = ST_EVAL;
      ST_EVAL: begin
        if (gt_q || hit || stop_nx) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_en       = 1'b0;
    conv_en       = 1'b0;
    len_en        = 1'b0;
    add_en        = 1'b0;
    eval_en       = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        load_en       = s_axis_tvalid;
      end
      ST_CONV: conv_en  = 1'b1;
      ST_LEN:  len_en   = 1'b1;
      ST_ADD:  add_en   = 1'b1;
      ST_EVAL: eval_en  = 1'b1;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Number of significant decimal digits of the current value
  always_comb begin
    len_c = '0;
    for (int i = 0; i < VAL_DIGITS; i++) begin
      if (cur_q[i] != 4'd0) begin
        len_c = DIG_W'(i + 1);
      end
    end
  end

  // One decimal digit of value + reversal per cycle
  assign dig_in_val = (dig_q < DIG_W'(VAL_DIGITS));
  assign dig_in_rev = (dig_q < len_q);
  assign rev_idx    = len_q - DIG_W'(1) - dig_q;
  assign dig_a      = dig_in_val ? cur_q[dig_q] : 4'd0;
  assign dig_b      = dig_in_rev ? cur_q[rev_idx] : 4'd0;
  assign dig_t      = dig_in_val ? tgt_q[dig_q] : 4'd0;
  assign dig_raw    = {1'b0, dig_a} + {1'b0, dig_b} + {4'd0, carry_q};
  assign dig_c      = (dig_raw >= 5'd10);
  assign dig_s      = dig_c ? 4'(dig_raw - 5'd10) : dig_raw[3:0];

  // Datapath
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      bin_q  <= s_axis_tdata[VAL_W-1:0];
      tag_q  <= s_axis_tdata[2*VAL_W-1:VAL_W];
      tbin_q <= target_q;
      cur_q  <= '0;
      tgt_q  <= '0;
    end
    if (conv_en) begin
      cur_q  <= dabble(cur_q, bin_q[VAL_W-1]);
      tgt_q  <= dabble(tgt_q, tbin_q[VAL_W-1]);
      bin_q  <= {bin_q[VAL_W-2:0], 1'b0};
      tbin_q <= {tbin_q[VAL_W-2:0], 1'b0};
    end
    if (len_en) begin
      len_q   <= len_c;
      carry_q <= 1'b0;
      gt_q    <= 1'b0;
      eq_q    <= 1'b1;
    end
    if (add_en) begin
      sum_q   <= {dig_s, sum_q[SUM_DIGITS-1:1]};
      carry_q <= dig_c;
      // Least significant digit first: a later differing digit decides
      if (dig_s > INT_MAX_BCD[dig_q]) begin
        gt_q <= 1'b1;
      end else if (dig_s < INT_MAX_BCD[dig_q]) begin
        gt_q <= 1'b0;
      end
      if (dig_s != dig_t) begin
        eq_q <= 1'b0;
      end
    end
    if (eval_en) begin
      found_q <= !gt_q && hit;
      ovf_q   <= gt_q;
      if (!gt_q && !hit) begin
        cur_q <= sum_q[VAL_DIGITS-1:0];
      end
    end
  end

  // Bit, digit and step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      dig_q  <= '0;
      step_q <= '0;
    end else begin
      if (load_en) begin
        bit_q  <= '0;
        step_q <= STEP_W'(1);
      end else if (conv_en) begin
        bit_q <= bit_q + BITCNT_W'(1);
      end
      if (len_en) begin
        dig_q <= '0;
      end else if (add_en) begin
        dig_q <= dig_q + DIG_W'(1);
      end
      if (eval_en && !gt_q && !hit) begin
        step_q <= step_nx;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_found_q <= found_q;
      res_ovf_q   <= ovf_q;
      res_step_q  <= step_q[STEPS_W-1:0];
      res_tag_q   <= tag_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - VAL_W - STEPS_W - 2)'(0), res_tag_q,
                          res_step_q, res_ovf_q, res_found_q};

`ifndef SYNTHESIS
  // A digit pass always ends in the evaluation cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && add_last) |=> (state_q == ST_EVAL))
    else $error("digit pass did not end in evaluation");

  // A result is never both a match and an overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(res_found_q && res_ovf_q))
    else $error("result flagged as found and overflowed");

  // The step counter never runs past the iteration bound plus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_CONV) |->
      (step_q <= STEP_W'(ITER_LIMIT + 1)))
    else $error("step counter beyond iteration bound");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the reverse-and-add palindrome search block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rapal_pkg::*;

  localparam longint unsigned SUM_CEILING = 64'd2147483647;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLDOFF_CYCLES = 1500;
  localparam int HOLDOFF_AT = 60;
  localparam int DRAIN_CYCLES = 3500;

  // One request: start value in the low bits, tag above it
  typedef struct packed {
    logic [30:0] tag;
    logic [30:0] value;
  } search_req_t;

  // One result, laid out as on the result stream
  typedef struct packed {
    logic [30:0] tag;
    logic [8:0]  steps;
    logic        overflowed;
    logic        found;
  } search_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [VAL_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Mirror of the configuration registers
  int unsigned target_mirror = 0;
  int unsigned min_steps_mirror = 0;
  int unsigned max_steps_mirror = 256;

  search_req_t    pending_requests[$];
  search_result_t expected_results[$];
  int             requests_taken = 0;
  int             holdoff_left = 0;
  bit             holdoff_done = 1'b0;
  int             stall_cycles = 0;
  int             error_count = 0;
  logic           steady;

  // No idling on either side over this stretch of requests
  assign steady = (requests_taken >= 120) && (requests_taken < 170);

  reverse_add_palindrome_search u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned reverse_digits(longint unsigned v);
    longint unsigned r;
    r = 0;
    while (v != 0) begin
      r = r * 10 + v % 10;
      v = v / 10;
    end
    return r;
  endfunction

  // Expected outcome of one search under the current register settings
  function automatic search_result_t predict_search(search_req_t req);
    search_result_t  res;
    longint unsigned cur;
    longint unsigned sum;
    int unsigned     step;
    bit              done;
    res.found = 1'b0;
    res.overflowed = 1'b0;
    res.tag = req.tag;
    cur = req.value;
    step = 1;
    done = 1'b0;
    while (!done) begin
      sum = cur + reverse_digits(cur);
      if (sum > SUM_CEILING) begin
        res.overflowed = 1'b1;
        done = 1'b1;
      end else if (step >= min_steps_mirror && sum == target_mirror) begin
        res.found = 1'b1;
        done = 1'b1;
      end else begin
        cur = sum;
        step++;
        if ((step >= min_steps_mirror && step > max_steps_mirror) || step > ITER_LIMIT) begin
          done = 1'b1;
        end
      end
    end
    res.steps = step[8:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Register write, one cycle of write enable
  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[VAL_W-1:0];
    case (idx)
      REG_TARGET: begin
        target_mirror = value & 32'h7FFF_FFFF;
      end
      REG_MIN_STEPS: begin
        min_steps_mirror = value & 32'h1FF;
      end
      default: begin
        max_steps_mirror = value & 32'h1FF;
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic issue(longint unsigned value, longint unsigned tag);
    search_req_t req;
    req.value = value[30:0];
    req.tag = tag[30:0];
    pending_requests.push_back(req);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Request driver: holds the offered request until it is taken
  always @(posedge clk_i) begin : drive_requests
    bit offering;
    offering = s_axis_tvalid;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(predict_search(pending_requests[0]));
      void'(pending_requests.pop_front());
      requests_taken <= requests_taken + 1;
      offering = 1'b0;
    end
    if (!offering) begin
      if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, pending_requests[0]};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off once, so the block fills up and stalls its input
  always @(posedge clk_i) begin : result_holdoff
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && requests_taken == HOLDOFF_AT) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end
  end

  // Result monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    search_result_t got;
    search_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(search_result_t)-1:0];
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending, tag", got.tag, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.overflowed !== want.overflowed) begin
          report_mismatch("overflowed", got.overflowed, want.overflowed);
        end
        if (got.steps !== want.steps) report_mismatch("step_count", got.steps, want.steps);
        if (got.tag !== want.tag) report_mismatch("echoed_tag", got.tag, want.tag);
      end
    end
    m_axis_tready <= (holdoff_left == 0) && (steady || $urandom_range(99) >= 29);
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL reverse_add_palindrome_search");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    longint unsigned chain[41];
    longint unsigned seed;
    longint unsigned sum;
    longint unsigned start;
    int              chain_len;
    int              k;
    int              pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: zero target hit at once, full-width values, slow growers
    @(negedge clk_i);
    issue(0, 0);
    issue(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    issue(1, 31'h5555_5555);
    issue(196, 31'h2AAA_AAAA);
    issue(89, 1);
    issue(31'h0000_FFFF, 31'h7FFF_0000);
    issue(1000000000, 31'h0000_7FFF);
    wait_idle();

    // Zero never moves: runs to the iteration limit
    write_reg(REG_TARGET, 1);
    write_reg(REG_MIN_STEPS, 0);
    write_reg(REG_MAX_STEPS, 256);
    @(negedge clk_i);
    issue(0, 11);
    issue(31'h4000_0000, 12);
    wait_idle();

    // Palindrome target with a zero step budget
    write_reg(REG_TARGET, 121);
    write_reg(REG_MAX_STEPS, 0);
    @(negedge clk_i);
    issue(29, 21);
    issue(19, 22);
    issue(56, 23);
    wait_idle();

    // A match before the minimum step is passed over
    write_reg(REG_MIN_STEPS, 2);
    write_reg(REG_MAX_STEPS, 256);
    @(negedge clk_i);
    issue(19, 31);
    issue(29, 32);
    wait_idle();

    // Minimum above maximum: only the minimum ends the search
    write_reg(REG_TARGET, 0);
    write_reg(REG_MIN_STEPS, 256);
    write_reg(REG_MAX_STEPS, 0);
    @(negedge clk_i);
    issue(0, 41);
    issue(5, 42);
    wait_idle();

    // Largest target
    write_reg(REG_TARGET, 32'h7FFF_FFFF);
    write_reg(REG_MIN_STEPS, 0);
    write_reg(REG_MAX_STEPS, 256);
    @(negedge clk_i);
    issue(1073741823, 51);
    issue(1000000000, 52);
    issue(1073741824, 53);
    wait_idle();

    // Random phases: target taken from the sum sequence of a random seed
    for (int phase = 0; phase < 5; phase++) begin
      if ($urandom_range(1) == 0) begin
        seed = longint'($urandom_range(1, 999));
      end else begin
        seed = longint'(31'($urandom)) >> $urandom_range(4, 30);
      end
      if (seed == 0) seed = 1;
      chain[0] = seed;
      chain_len = 0;
      for (int n = 1; n <= 40; n++) begin
        sum = chain[n-1] + reverse_digits(chain[n-1]);
        if (sum > SUM_CEILING) break;
        chain[n] = sum;
        chain_len = n;
      end
      if (chain_len == 0) begin
        k = 0;
        write_reg(REG_TARGET, 32'(31'($urandom)));
      end else begin
        k = $urandom_range(1, chain_len);
        write_reg(REG_TARGET, 32'(chain[k]));
      end
      if (phase == 0) begin
        write_reg(REG_MIN_STEPS, 0);
        write_reg(REG_MAX_STEPS, 256);
      end else begin
        write_reg(REG_MIN_STEPS, $urandom_range(0, k));
        case ($urandom_range(3))
          0: write_reg(REG_MAX_STEPS, 0);
          1: write_reg(REG_MAX_STEPS, 256);
          default: write_reg(REG_MAX_STEPS, $urandom_range(0, 256));
        endcase
      end
      @(negedge clk_i);
      for (int i = 0; i < 40; i++) begin
        pick = $urandom_range(99);
        if (pick < 45 && k > 0) begin
          start = chain[$urandom_range(0, k - 1)];
        end else if (pick < 47) begin
          start = 0;
        end else begin
          start = longint'(31'($urandom)) >> $urandom_range(0, 30);
        end
        issue(start, longint'(31'($urandom)));
      end
      wait_idle();
    end

    // Let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS reverse_add_palindrome_search");
    end else begin
      $display("FAIL reverse_add_palindrome_search");
    end
    $finish;
  end

endmodule
